// File: hw/rtl/thss_pkg.sv
// types, constants and weight function shared by the trail spline sampler
`timescale 1ns / 1ps

package thss_pkg;

  localparam int COORD_W = 24;
  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int SPS = 4;
  localparam int PT_W = COORD_W + 2;
  localparam int DEN = 2 * SPS * SPS * SPS;
  localparam int DEN_SHIFT = $clog2(DEN);
  localparam int WGT_W = DEN_SHIFT + 2;
  localparam int J_W = $clog2(SPS);
  localparam int IDX_W = 6;
  localparam int SPACING_W = 16;
  localparam logic [SPACING_W-1:0] SPACING_RST = 16'd256;
  localparam int DIST_W = 64;

  localparam logic REQ_RESTART = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PT_W-1:0] pcoord_t;
  // index 0 is x, 1 is y, 2 is z
  typedef coord_t [2:0] entry_t;
  typedef pcoord_t [2:0] point_t;

  typedef struct packed {
    logic req_type;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [IDX_W-1:0] sample_index;
    logic last;
  } out_item_t;

  // one sample request: four control points, fraction step, ordinal and last flag
  typedef struct packed {
    point_t [3:0] win;
    logic [J_W-1:0] j;
    logic [IDX_W-1:0] idx;
    logic last;
  } sample_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIST,
    ST_ACC,
    ST_DECIDE,
    ST_LOAD,
    ST_SAMPLE
  } state_t;

  // catmull-rom basis weight of control point k at fraction j/SPS, scaled by DEN
  function automatic logic signed [WGT_W-1:0] weight(input logic [J_W-1:0] j,
                                                      input logic [1:0] k);
    int jj;
    int j2;
    int j3;
    int w;
    jj = int'(j);
    j2 = jj * jj;
    j3 = j2 * jj;
    case (k)
      2'd0: w = -j3 + 2 * j2 * SPS - jj * SPS * SPS;
      2'd1: w = 2 * SPS * SPS * SPS - 5 * j2 * SPS + 3 * j3;
      2'd2: w = -3 * j3 + 4 * j2 * SPS + jj * SPS * SPS;
      default: w = j3 - j2 * SPS;
    endcase
    return WGT_W'(w);
  endfunction

endpackage

// File: hw/rtl/trail_history_spline_sampler.sv
// top level of the trail history spline sampler
`timescale 1ns / 1ps

// Usage:
// - in channel (in_valid / in_stall / in_data): one item per tick with the
//   current position; req_type restarts the trail, and the first item after
//   reset always restarts it.
// - out channel (out_valid / out_stall / out_data): 4*(HISTORY_DEPTH+1)-1
//   spline samples per item (35 at depth 8), sample_index counting from 0,
//   last set on the final one.
// - cfg_we / cfg_data write min_spacing; write only while the block is idle.
// Sequence: after an item is taken the sequencer does the newest-entry read,
// the squared distance (one coordinate per cycle), the append decision and
// three history reads, then issues one sample per cycle unless out_stall holds
// the pipe. An issued sample passes the product register, then the output
// register. An item occupies the block until its last sample is issued; the
// single-port history memory and the one-sample-per-cycle evaluator set this.
// Reset clears the history valid bits, sequencer state, newest pointer,
// min_spacing and pipe valid bits; no clearing pass is needed. With out_valid
// and out_stall high the output register, pipe and sample issue all hold.

module trail_history_spline_sampler #(
  parameter int HISTORY_DEPTH = thss_pkg::HISTORY_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  thss_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output thss_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic [thss_pkg::SPACING_W-1:0] cfg_data
);

  logic smp_valid;
  logic smp_ready;
  thss_pkg::sample_t smp_data;

  thss_ctrl #(
    .DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .smp_valid(smp_valid),
    .smp_ready(smp_ready),
    .smp_data(smp_data)
  );

  thss_interp u_interp (
    .clk(clk),
    .rst(rst),
    .smp_valid(smp_valid),
    .smp_ready(smp_ready),
    .smp_data(smp_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule

// File: hw/rtl/thss_ctrl.sv
// history ring memory, spacing check and control point sequencer
`timescale 1ns / 1ps

module thss_ctrl #(
  parameter int DEPTH = thss_pkg::HISTORY_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  thss_pkg::in_item_t in_data,
  input  logic cfg_we,
  input  logic [thss_pkg::SPACING_W-1:0] cfg_data,
  output logic smp_valid,
  input  logic smp_ready,
  output thss_pkg::sample_t smp_data
);

  localparam int CW = thss_pkg::COORD_W;
  localparam int PW = thss_pkg::PT_W;
  localparam int DW = thss_pkg::DIST_W;
  localparam int IW = thss_pkg::IDX_W;
  localparam int JW = thss_pkg::J_W;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SEG_W = $clog2(DEPTH + 2);
  localparam int TOTAL = thss_pkg::SPS * (DEPTH + 1) - 1;
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
  localparam logic [1:0] CNT_END = 2'd2;

  function automatic thss_pkg::point_t to_point(input thss_pkg::entry_t e);
    thss_pkg::point_t p;
    for (int c = 0; c < 3; c++) begin
      p[c] = {{(PW - CW){e[c][CW-1]}}, e[c]};
    end
    return p;
  endfunction

  // 2*a - b per coordinate, used for both extrapolated end points
  function automatic thss_pkg::point_t reflect(input thss_pkg::point_t a,
                                               input thss_pkg::point_t b);
    thss_pkg::point_t p;
    for (int c = 0; c < 3; c++) begin
      p[c] = PW'((a[c] <<< 1) - b[c]);
    end
    return p;
  endfunction

  thss_pkg::state_t state, state_next;

  logic primed;
  logic [ADDR_W-1:0] newest;
  logic [ADDR_W-1:0] newest_inc;
  logic [ADDR_W-1:0] rslot;
  logic [ADDR_W-1:0] rslot_dec;
  logic [thss_pkg::SPACING_W-1:0] min_spacing;

  thss_pkg::entry_t cur;
  thss_pkg::entry_t fill;
  logic [1:0] cnt;
  logic [DW-1:0] sq_dist;
  logic [DW-1:0] sq;
  logic [DW-1:0] thr;
  logic [DW-1:0] dist_sum;
  logic [DW:0] add_full;
  logic append;

  thss_pkg::point_t [3:0] win;
  logic [SEG_W-1:0] seg;
  logic [JW-1:0] j;
  logic [IW-1:0] idx;
  logic last_j;
  logic last_sample;

  logic accept;
  logic restart;
  logic fire;

  // history ring memory
  thss_pkg::entry_t ram [DEPTH];
  logic [DEPTH-1:0] valid;
  thss_pkg::entry_t q;
  logic q_valid;
  thss_pkg::entry_t rd_data;
  logic mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic mem_wr_en;

  logic signed [CW:0] diff;
  logic [CW:0] mag;
  logic [2*CW+1:0] sq_full;

  assign newest_inc = (newest == LAST_SLOT) ? '0 : newest + ADDR_W'(1);
  assign rslot_dec = (rslot == '0) ? LAST_SLOT : rslot - ADDR_W'(1);
  assign restart = (in_data.req_type == thss_pkg::REQ_RESTART) || !primed;
  assign last_j = (j == JW'(thss_pkg::SPS - 1));
  assign last_sample = (idx == IW'(TOTAL - 1));

  // entries never written since the last restart read as the restart position
  assign rd_data = q_valid ? q : fill;

  // squared distance, one coordinate per cycle
  assign diff = {cur[cnt][CW-1], cur[cnt]} - {rd_data[cnt][CW-1], rd_data[cnt]};
  assign mag = diff[CW] ? $unsigned(-diff) : $unsigned(diff);
  assign sq_full = {{(CW + 1){1'b0}}, mag} * {{(CW + 1){1'b0}}, mag};
  assign add_full = {1'b0, sq_dist} + {1'b0, sq};
  assign dist_sum = add_full[DW] ? '1 : add_full[DW-1:0];
  assign append = (sq_dist > thr);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      thss_pkg::ST_IDLE: begin
        if (accept) state_next = thss_pkg::ST_READ;
      end
      thss_pkg::ST_READ: state_next = thss_pkg::ST_DIST;
      thss_pkg::ST_DIST: begin
        if (cnt == CNT_END) state_next = thss_pkg::ST_ACC;
      end
      thss_pkg::ST_ACC: state_next = thss_pkg::ST_DECIDE;
      thss_pkg::ST_DECIDE: state_next = thss_pkg::ST_LOAD;
      thss_pkg::ST_LOAD: begin
        if (cnt == CNT_END) state_next = thss_pkg::ST_SAMPLE;
      end
      thss_pkg::ST_SAMPLE: begin
        if (fire && last_sample) state_next = thss_pkg::ST_IDLE;
      end
      default: state_next = thss_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = rst || (state != thss_pkg::ST_IDLE);
    accept = in_valid && !in_stall;
    smp_valid = (state == thss_pkg::ST_SAMPLE);
    fire = smp_valid && smp_ready;
    mem_wr_en = (state == thss_pkg::ST_DECIDE) && append;
    mem_rd_addr = rslot;
    case (state)
      thss_pkg::ST_READ: begin
        mem_rd_en = 1'b1;
        mem_rd_addr = newest;
      end
      thss_pkg::ST_LOAD: mem_rd_en = 1'b1;
      thss_pkg::ST_SAMPLE: mem_rd_en = fire && last_j;
      default: mem_rd_en = 1'b0;
    endcase
  end

  always_comb begin
    smp_data.win = win;
    // past the last segment the oldest entry is repeated exactly
    smp_data.j = (seg > SEG_W'(DEPTH)) ? '0 : j;
    smp_data.idx = idx;
    smp_data.last = last_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= thss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
      newest <= '0;
      min_spacing <= thss_pkg::SPACING_RST;
      valid <= '0;
    end else begin
      if (cfg_we) min_spacing <= cfg_data;
      if (accept && restart) begin
        primed <= 1'b1;
        newest <= '0;
        valid <= '0;
      end else if (mem_wr_en) begin
        newest <= newest_inc;
        valid[newest_inc] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr_en) ram[newest_inc] <= cur;
    if (mem_rd_en) begin
      q <= ram[mem_rd_addr];
      q_valid <= valid[mem_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      thss_pkg::ST_IDLE: begin
        if (accept) begin
          cur[0] <= in_data.pos_x;
          cur[1] <= in_data.pos_y;
          cur[2] <= in_data.pos_z;
          if (restart) begin
            fill[0] <= in_data.pos_x;
            fill[1] <= in_data.pos_y;
            fill[2] <= in_data.pos_z;
          end
        end
      end
      thss_pkg::ST_READ: begin
        sq_dist <= '0;
        cnt <= '0;
        thr <= DW'({{thss_pkg::SPACING_W{1'b0}}, min_spacing}
                   * {{thss_pkg::SPACING_W{1'b0}}, min_spacing});
      end
      thss_pkg::ST_DIST: begin
        sq <= DW'(sq_full);
        if (cnt != '0) sq_dist <= dist_sum;
        cnt <= cnt + 2'd1;
      end
      thss_pkg::ST_ACC: begin
        sq_dist <= dist_sum;
      end
      thss_pkg::ST_DECIDE: begin
        rslot <= append ? newest_inc : newest;
        win[0] <= reflect(to_point(cur), to_point(rd_data));
        win[1] <= to_point(cur);
        cnt <= '0;
      end
      thss_pkg::ST_LOAD: begin
        rslot <= rslot_dec;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd1) win[2] <= to_point(rd_data);
        if (cnt == CNT_END) win[3] <= to_point(rd_data);
        seg <= SEG_W'(1);
        j <= JW'(1);
        idx <= '0;
      end
      thss_pkg::ST_SAMPLE: begin
        if (fire) begin
          idx <= idx + IW'(1);
          if (last_j) begin
            j <= '0;
            seg <= seg + SEG_W'(1);
            rslot <= rslot_dec;
            win[0] <= win[1];
            win[1] <= win[2];
            win[2] <= win[3];
            win[3] <= (seg == SEG_W'(DEPTH - 1)) ? reflect(win[3], win[2])
                                                 : to_point(rd_data);
          end else begin
            j <= j + JW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/thss_interp.sv
// two-stage spline evaluator with rounding, saturation and output register
`timescale 1ns / 1ps

module thss_interp (
  input  logic clk,
  input  logic rst,
  input  logic smp_valid,
  output logic smp_ready,
  input  thss_pkg::sample_t smp_data,
  output logic out_valid,
  input  logic out_stall,
  output thss_pkg::out_item_t out_data
);

  localparam int CW = thss_pkg::COORD_W;
  localparam int PROD_W = thss_pkg::PT_W + thss_pkg::WGT_W;
  localparam int ACC_W = PROD_W + 2;
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(thss_pkg::DEN / 2);

  logic move;
  logic v1;
  logic signed [PROD_W-1:0] prod [3][4];
  logic [thss_pkg::IDX_W-1:0] idx1;
  logic last1;
  logic signed [ACC_W-1:0] acc [3];
  logic signed [ACC_W-1:0] scaled [3];
  logic signed [CW-1:0] res [3];

  // the whole pipe advances together whenever the output register frees up
  assign move = !out_valid || !out_stall;
  assign smp_ready = move;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (move) begin
      v1 <= smp_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (move && smp_valid) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) begin
          prod[c][k] <= PROD_W'($signed(smp_data.win[k][c]))
                      * PROD_W'(thss_pkg::weight(smp_data.j, 2'(k)));
        end
      end
      idx1 <= smp_data.idx;
      last1 <= smp_data.last;
    end
  end

  // round half up, then clamp to the coordinate range
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = ACC_W'(prod[c][0]) + ACC_W'(prod[c][1]) + ACC_W'(prod[c][2])
             + ACC_W'(prod[c][3]) + ROUND;
      scaled[c] = acc[c] >>> thss_pkg::DEN_SHIFT;
      if (scaled[c][ACC_W-1:CW-1] == '0 || scaled[c][ACC_W-1:CW-1] == '1) begin
        res[c] = scaled[c][CW-1:0];
      end else if (scaled[c][ACC_W-1]) begin
        res[c] = {1'b1, {(CW - 1){1'b0}}};
      end else begin
        res[c] = {1'b0, {(CW - 1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move && v1) begin
      out_data.out_x <= res[0];
      out_data.out_y <= res[1];
      out_data.out_z <= res[2];
      out_data.sample_index <= idx1;
      out_data.last <= last1;
    end
  end

endmodule

// File: hw/rtl/thss_checker.sv
// port-level checks for the trail history spline sampler, bound to the top
`timescale 1ns / 1ps

module thss_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input thss_pkg::out_item_t out_data
);

  // a stalled item stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled output item dropped");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled output item changed");

  // one item at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // samples of one tick come out back to back in order
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last |=>
      out_valid && (out_data.sample_index == $past(out_data.sample_index) + 6'd1))
    else $error("sample sequence broken");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_data.last |=> !out_valid)
    else $error("sample after the final one of a tick");

endmodule

bind trail_history_spline_sampler thss_checker u_thss_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data(out_data)
);
